[rtl/positional_char_list_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the positional character list
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_CHAR_LIST_ASSERT_SVH
`define POSITIONAL_CHAR_LIST_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("positional_char_list: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PCL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("positional_char_list: next-cycle check failed");

`endif

[rtl/pcl_pkg.sv]
// ----------------------------------------------------------------------------
// Positional character list package
// Command codes, cell operations and the control group shared by the modules.
// ----------------------------------------------------------------------------
package pcl_pkg;

	localparam int unsigned LIST_DEPTH_DEF = 64;

	localparam int unsigned CMD_W   = 3;
	localparam int unsigned POS_W   = 7;
	localparam int unsigned DATA_W  = 8;
	localparam int unsigned LENGTH_W = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND   = 3'd0,
		CMD_REM_HEAD = 3'd1,
		CMD_REM_AT   = 3'd2,
		CMD_READ     = 3'd3,
		CMD_INSERT   = 3'd4,
		CMD_CLEAR    = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2
	} op_t;

	// Broadcast from the controller to every cell and to the result stage.
	typedef struct packed {
		op_t  op;
		logic rd_en;
		logic err;
	} ctrl_t;

endpackage

[rtl/positional_char_list.sv]
// ----------------------------------------------------------------------------
// Positional character list
// Ordered byte list held in a row of cells that shift on insert and remove.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+------------------------------
//  command   | start, busy        | cmd, position, value_in
//  result    | done (strobe)      | value_out, length, error
//
// One command is taken in every cycle; busy never rises. Each command gives
// one result beat on the cycle after it is taken, with done high for that
// cycle only. The cell row shifts on acceptance, and the read path is an
// AND-OR selection over all cells. Reset clears the fill count and the result
// strobe at once; stored bytes are not cleared. The receiver cannot stall.
// ----------------------------------------------------------------------------
`include "positional_char_list_assert.svh"

module positional_char_list #(
	parameter int unsigned LIST_DEPTH = pcl_pkg::LIST_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [pcl_pkg::CMD_W-1:0]     cmd,
	input  logic [pcl_pkg::POS_W-1:0]     position,
	input  logic [pcl_pkg::DATA_W-1:0]    value_in,
	output logic                          done,
	output logic [pcl_pkg::DATA_W-1:0]    value_out,
	output logic [pcl_pkg::LENGTH_W-1:0]  length,
	output logic                          error
);
	import pcl_pkg::*;

	localparam int unsigned IDX_W = $clog2(LIST_DEPTH + 1);

	logic                  accept;
	ctrl_t                 ctrl;
	logic [IDX_W-1:0]      idx;
	logic [IDX_W-1:0]      fill;
	logic [IDX_W-1:0]      fill_next;
	logic [DATA_W-1:0]     cell_data [LIST_DEPTH];
	logic [LIST_DEPTH-1:0] cell_hit;
	logic [DATA_W-1:0]     read_byte;
	logic [DATA_W-1:0]     got;

	logic                  done_q;
	logic [DATA_W-1:0]     value_out_q;
	logic [LENGTH_W-1:0]   length_q;
	logic                  error_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	pcl_ctrl #(
		.LIST_DEPTH (LIST_DEPTH),
		.IDX_W      (IDX_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.cmd       (cmd),
		.position  (position),
		.ctrl      (ctrl),
		.idx       (idx),
		.fill      (fill),
		.fill_next (fill_next)
	);

	for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
		logic [DATA_W-1:0] left_d;
		logic [DATA_W-1:0] right_d;

		if (k == 0) begin : g_head
			assign left_d = '0;
		end else begin : g_body
			assign left_d = cell_data[k-1];
		end

		if (k == LIST_DEPTH - 1) begin : g_tail
			assign right_d = '0;
		end else begin : g_inner
			assign right_d = cell_data[k+1];
		end

		pcl_cell #(
			.IDX_W (IDX_W),
			.K     (k)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.idx        (idx),
			.value_in   (value_in),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[k]),
			.hit        (cell_hit[k])
		);
	end

	// At most one cell matches the index, so an OR of masked bytes selects it.
	always_comb begin
		read_byte = '0;
		for (int unsigned k = 0; k < LIST_DEPTH; k++) begin
			read_byte = read_byte | (cell_data[k] & {DATA_W{cell_hit[k]}});
		end
	end

	assign got = ctrl.rd_en ? read_byte : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_out_q <= got;
			length_q    <= LENGTH_W'(fill_next);
			error_q     <= ctrl.err;
		end
	end

	assign done      = done_q;
	assign value_out = value_out_q;
	assign length    = length_q;
	assign error     = error_q;

	`PCL_ASSERT_NEXT(a_beat_follows_accept, accept, done)
	`PCL_ASSERT_NOW(a_error_no_byte, done && error, value_out == '0)
	`PCL_ASSERT_NOW(a_fill_in_range, 1'b1, fill <= IDX_W'(LIST_DEPTH))
	`PCL_ASSERT_NEXT(a_clear_empties, accept && (cmd == CMD_CLEAR), (fill == '0) && !error)

endmodule

[rtl/pcl_cell.sv]
// ----------------------------------------------------------------------------
// Positional character list cell
// Holds one stored byte and takes it from a neighbour when the list shifts.
// ----------------------------------------------------------------------------
module pcl_cell #(
	parameter int unsigned IDX_W = 7,
	parameter int unsigned K     = 0
) (
	input  logic                      clk,
	input  pcl_pkg::ctrl_t            ctrl,
	input  logic [IDX_W-1:0]          idx,
	input  logic [pcl_pkg::DATA_W-1:0] value_in,
	input  logic [pcl_pkg::DATA_W-1:0] left_data,
	input  logic [pcl_pkg::DATA_W-1:0] right_data,
	output logic [pcl_pkg::DATA_W-1:0] data,
	output logic                      hit
);
	import pcl_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(K);

	logic [DATA_W-1:0] slot_q;
	logic [DATA_W-1:0] slot_d;
	logic              at_idx;
	logic              past_idx;

	assign at_idx   = (idx == MY_IDX);
	assign past_idx = (MY_IDX > idx);

	always_comb begin
		slot_d = slot_q;
		unique case (ctrl.op)
			OP_INSERT: begin
				if (at_idx) begin
					slot_d = value_in;
				end else if (past_idx) begin
					slot_d = left_data;
				end
			end
			OP_REMOVE: begin
				if (at_idx || past_idx) begin
					slot_d = right_data;
				end
			end
			default: begin
				slot_d = slot_q;
			end
		endcase
	end

	// Contents are undefined until written, so the slot needs no reset.
	always_ff @(posedge clk) begin
		slot_q <= slot_d;
	end

	assign data = slot_q;
	assign hit  = at_idx;

endmodule

[rtl/pcl_ctrl.sv]
// ----------------------------------------------------------------------------
// Positional character list controller
// Checks each command against the fill count and drives the cell row.
// ----------------------------------------------------------------------------
module pcl_ctrl #(
	parameter int unsigned LIST_DEPTH = pcl_pkg::LIST_DEPTH_DEF,
	parameter int unsigned IDX_W      = $clog2(LIST_DEPTH + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [pcl_pkg::CMD_W-1:0]    cmd,
	input  logic [pcl_pkg::POS_W-1:0]    position,
	output pcl_pkg::ctrl_t               ctrl,
	output logic [IDX_W-1:0]             idx,
	output logic [IDX_W-1:0]             fill,
	output logic [IDX_W-1:0]             fill_next
);
	import pcl_pkg::*;

	localparam int unsigned CMP_W = ((IDX_W > POS_W) ? IDX_W : POS_W) + 1;
	localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(LIST_DEPTH);
	localparam logic [CMP_W-1:0] ONE_C   = CMP_W'(1);
	localparam logic [IDX_W-1:0] ONE_I   = IDX_W'(1);

	logic [IDX_W-1:0] fill_q;
	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] fill_x;
	logic             pos_rd_ok;
	logic             pos_ins_ok;
	logic             full;
	ctrl_t            ctrl_raw;
	logic [IDX_W-1:0] idx_pos;
	logic [IDX_W-1:0] fill_d;

	assign pos_x      = CMP_W'(position);
	assign fill_x     = CMP_W'(fill_q);
	assign full       = (fill_x >= DEPTH_C);
	assign pos_rd_ok  = (pos_x != '0) && (pos_x <= fill_x);
	assign pos_ins_ok = (pos_x != '0) && (pos_x <= fill_x + ONE_C) && !full;
	assign idx_pos    = IDX_W'(pos_x - ONE_C);

	always_comb begin
		ctrl_raw = '{op: OP_HOLD, rd_en: 1'b0, err: 1'b0};
		idx      = idx_pos;
		fill_d   = fill_q;
		unique case (cmd)
			CMD_APPEND: begin
				idx = fill_q;
				if (full) begin
					ctrl_raw.err = 1'b1;
				end else begin
					ctrl_raw.op = OP_INSERT;
					fill_d      = fill_q + ONE_I;
				end
			end
			CMD_REM_HEAD: begin
				idx = '0;
				if (fill_q == '0) begin
					ctrl_raw.err = 1'b1;
				end else begin
					ctrl_raw.op    = OP_REMOVE;
					ctrl_raw.rd_en = 1'b1;
					fill_d         = fill_q - ONE_I;
				end
			end
			CMD_REM_AT: begin
				if (!pos_rd_ok) begin
					ctrl_raw.err = 1'b1;
				end else begin
					ctrl_raw.op    = OP_REMOVE;
					ctrl_raw.rd_en = 1'b1;
					fill_d         = fill_q - ONE_I;
				end
			end
			CMD_READ: begin
				if (!pos_rd_ok) begin
					ctrl_raw.err = 1'b1;
				end else begin
					ctrl_raw.rd_en = 1'b1;
				end
			end
			CMD_INSERT: begin
				if (!pos_ins_ok) begin
					ctrl_raw.err = 1'b1;
				end else begin
					ctrl_raw.op = OP_INSERT;
					fill_d      = fill_q + ONE_I;
				end
			end
			CMD_CLEAR: begin
				fill_d = '0;
			end
			default: begin
				ctrl_raw.err = 1'b1;
			end
		endcase
	end

	// Cells only move on an accepted command.
	always_comb begin
		ctrl = ctrl_raw;
		if (!accept) begin
			ctrl.op = OP_HOLD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= fill_d;
		end
	end

	assign fill      = fill_q;
	assign fill_next = fill_d;

endmodule

[dv/positional_char_list_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional character list testbench
// Drives list commands through the start/busy handshake and checks every result
// beat against a shadow copy of the list. A short directed run covers the
// corner cases, then random traffic fills and drains the list repeatedly.
// The sender pauses at two different rates and also runs without pauses.
// ----------------------------------------------------------------------------
module positional_char_list_test;
	import pcl_pkg::*;

	localparam int unsigned DEPTH = LIST_DEPTH_DEF;

	typedef struct {
		bit [DATA_W-1:0]   value;
		bit [LENGTH_W-1:0] count;
		bit                err;
	} list_reply_t;

	// Shadow of the list contents and queue of the replies still owed by the block.
	class char_list_tracker;
		bit [DATA_W-1:0] slots [DEPTH];
		int unsigned     fill;
		list_reply_t     owed [$];
		int unsigned     mismatches;

		function new();
			fill = 0;
			mismatches = 0;
		endfunction

		function void shift_out(int unsigned idx);
			for (int unsigned k = idx; k + 1 < fill; k++)
				slots[k] = slots[k + 1];
			fill--;
		endfunction

		function void shift_in(int unsigned idx, bit [DATA_W-1:0] v);
			for (int unsigned k = fill; k > idx; k--)
				slots[k] = slots[k - 1];
			slots[idx] = v;
			fill++;
		endfunction

		// Applies one accepted command beat and queues the reply it should give.
		function void take_command(cmd_t op, bit [POS_W-1:0] pos, bit [DATA_W-1:0] v);
			list_reply_t r;
			r.value = '0;
			r.err = 1'b0;
			case (op)
				CMD_APPEND: begin
					if (fill >= DEPTH)
						r.err = 1'b1;
					else
						shift_in(fill, v);
				end
				CMD_REM_HEAD: begin
					if (fill == 0) begin
						r.err = 1'b1;
					end else begin
						r.value = slots[0];
						shift_out(0);
					end
				end
				CMD_REM_AT: begin
					if (pos < 1 || pos > fill) begin
						r.err = 1'b1;
					end else begin
						r.value = slots[pos - 1];
						shift_out(pos - 1);
					end
				end
				CMD_READ: begin
					if (pos < 1 || pos > fill)
						r.err = 1'b1;
					else
						r.value = slots[pos - 1];
				end
				CMD_INSERT: begin
					if (pos < 1 || pos > fill + 1 || fill >= DEPTH)
						r.err = 1'b1;
					else
						shift_in(pos - 1, v);
				end
				CMD_CLEAR: fill = 0;
				default: r.err = 1'b1;
			endcase
			r.count = fill[LENGTH_W-1:0];
			owed.push_back(r);
		endfunction

		task report(string msg);
			$display("%0t: MISMATCH %s", $realtime, msg);
			mismatches++;
		endtask

		task check_reply(logic [DATA_W-1:0] v, logic [LENGTH_W-1:0] n, logic e);
			list_reply_t want;
			if (owed.size() == 0) begin
				report($sformatf(
					"result beat with nothing outstanding (value %h length %0d error %b)",
					v, n, e));
			end else begin
				want = owed.pop_front();
				if (v !== want.value)
					report($sformatf("value_out %h, expected %h", v, want.value));
				if (n !== want.count)
					report($sformatf("length %0d, expected %0d", n, want.count));
				if (e !== want.err)
					report($sformatf("error %b, expected %b", e, want.err));
			end
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [CMD_W-1:0]    cmd;
	logic [POS_W-1:0]    position;
	logic [DATA_W-1:0]   value_in;
	logic                done;
	logic [DATA_W-1:0]   value_out;
	logic [LENGTH_W-1:0] length;
	logic                error;

	char_list_tracker list_model = new();

	positional_char_list uut (clk, arst_n, start, busy, cmd, position, value_in,
		done, value_out, length, error);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done === 1'b1)
				list_model.check_reply(value_out, length, error);
			if (start && busy === 1'b0)
				list_model.take_command(cmd_t'(cmd), position, value_in);
		end
	end

	initial begin
		#2_000_000;
		$display("positional_char_list test failed");
		$finish;
	end

	// Called just after a falling edge; returns on the falling edge after acceptance.
	task automatic issue(cmd_t op, bit [POS_W-1:0] pos, bit [DATA_W-1:0] v);
		start <= 1'b1;
		cmd <= op;
		position <= pos;
		value_in <= v;
		do @(posedge clk); while (busy !== 1'b0);
		@(negedge clk);
	endtask

	task automatic pause(int unsigned pct);
		if ($urandom_range(99) < pct) begin
			start <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < pct);
		end
	endtask

	task automatic send(int unsigned pct, cmd_t op, bit [POS_W-1:0] pos, bit [DATA_W-1:0] v);
		pause(pct);
		issue(op, pos, v);
	endtask

	function automatic bit [POS_W-1:0] pick_position(int unsigned top);
		int unsigned r;
		r = $urandom_range(99);
		if (r < 6)
			return '0;
		if (r < 14)
			return POS_W'($urandom_range(DEPTH));
		if (r < 22)
			return POS_W'((top + 1 > DEPTH) ? DEPTH : top + 1);
		if (top == 0)
			return POS_W'(1);
		return POS_W'($urandom_range(1, (top > DEPTH) ? DEPTH : top));
	endfunction

	function automatic bit [DATA_W-1:0] pick_byte();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10)
			return '0;
		if (r < 20)
			return '1;
		return DATA_W'($urandom_range(255));
	endfunction

	// Random traffic that swings between growing the list to full and draining it.
	task automatic random_run(int unsigned beats, int unsigned pct);
		bit          growing;
		int unsigned r;
		cmd_t        op;
		growing = 1'b1;
		repeat (beats) begin
			pause(pct);
			if (growing && list_model.fill == DEPTH && $urandom_range(7) == 0)
				growing = 1'b0;
			else if (!growing && list_model.fill == 0 && $urandom_range(3) == 0)
				growing = 1'b1;
			r = $urandom_range(99);
			if (growing)
				op = (r < 42) ? CMD_APPEND : (r < 77) ? CMD_INSERT : (r < 87) ? CMD_READ :
					(r < 92) ? CMD_REM_HEAD : (r < 99) ? CMD_REM_AT : CMD_CLEAR;
			else
				op = (r < 8) ? CMD_APPEND : (r < 16) ? CMD_INSERT : (r < 32) ? CMD_READ :
					(r < 60) ? CMD_REM_HEAD : (r < 97) ? CMD_REM_AT : CMD_CLEAR;
			issue(op, pick_position((op == CMD_INSERT) ? list_model.fill + 1 : list_model.fill),
				pick_byte());
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_APPEND;
		position = '0;
		value_in = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty list, position zero and positions past the end, then inserts at
		// the head and at the end, removals and a clear of a populated list.
		send(27, CMD_REM_HEAD, 0, 8'h00);
		send(27, CMD_REM_AT, 1, 8'h00);
		send(27, CMD_READ, 1, 8'h00);
		send(27, CMD_INSERT, 0, 8'h11);
		send(27, CMD_INSERT, 2, 8'h22);
		send(27, CMD_INSERT, 1, 8'h00);
		send(27, CMD_APPEND, 0, 8'hFF);
		send(27, CMD_INSERT, 3, 8'hA5);
		send(27, CMD_INSERT, 1, 8'h5A);
		send(27, CMD_READ, 0, 8'h00);
		send(27, CMD_READ, 4, 8'h00);
		send(27, CMD_READ, 5, 8'h00);
		send(27, CMD_REM_AT, 0, 8'h00);
		send(27, CMD_REM_AT, 5, 8'h00);
		send(27, CMD_REM_AT, 2, 8'h00);
		send(27, CMD_REM_HEAD, 0, 8'h00);
		send(27, CMD_READ, 64, 8'hFF);
		send(27, CMD_INSERT, 64, 8'hFF);
		send(27, CMD_CLEAR, 0, 8'h00);
		send(27, CMD_CLEAR, 0, 8'h00);
		send(27, CMD_REM_HEAD, 0, 8'h00);
		send(27, CMD_APPEND, 0, 8'h7F);
		send(27, CMD_REM_AT, 1, 8'h00);

		random_run(300, 27);
		random_run(250, 82);
		random_run(300, 0);
		start <= 1'b0;

		while (list_model.owed.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (list_model.mismatches == 0 && list_model.owed.size() == 0)
			$display("positional_char_list test passed");
		else
			$display("positional_char_list test failed");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/pcl_pkg.sv
rtl/pcl_cell.sv
rtl/pcl_ctrl.sv
rtl/positional_char_list.sv
dv/positional_char_list_test.sv
